// File: rtl/dhmd_pkg.sv
// Package for the decimal header message deframer.
// Holds field widths, ASCII digit bounds and the result kind codes.
// No dependencies.
package dhmd_pkg;

    localparam int TYPE_W  = 20;
    localparam int LEN_W   = 32;
    localparam int BYTE_W  = 8;
    localparam int OUT_DATA_W = 64;

    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

    typedef enum logic
    {
        KIND_HEADER  = 1'b0,
        KIND_PAYLOAD = 1'b1
    } kind_t;

endpackage

// File: rtl/dhmd_digit_acc.sv
// Decimal digit accumulator: acc * 10 + digit, saturating at all ones.
// Flags a non-digit byte or a saturated result.
// Depends on dhmd_pkg.
module dhmd_digit_acc #(
    parameter int W = 32
) (
    input  logic [W-1:0]              acc,
    input  logic [dhmd_pkg::BYTE_W-1:0] byte_in,
    output logic [W-1:0]              acc_out,
    output logic                      err
);

    logic              is_digit;
    logic [3:0]        digit;
    logic [W+3:0]      prod;
    logic [W+3:0]      sum;
    logic              sat;

    always_comb
    begin
        is_digit = (byte_in >= dhmd_pkg::ASCII_ZERO) && (byte_in <= dhmd_pkg::ASCII_NINE);
        digit    = 4'(byte_in - dhmd_pkg::ASCII_ZERO);
        // acc * 10 as (acc << 3) + (acc << 1)
        prod     = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
        sum      = prod + (W+4)'(digit);
        sat      = (sum[W+3:W] != 4'd0);
        if (!is_digit)
        begin
            acc_out = acc;
            err     = 1'b1;
        end
        else if (sat)
        begin
            acc_out = {W{1'b1}};
            err     = 1'b1;
        end
        else
        begin
            acc_out = sum[W-1:0];
            err     = 1'b0;
        end
    end

endmodule

// File: rtl/decimal_header_message_deframer.sv
// Top level of the decimal header message deframer.
// Instantiates dhmd_digit_acc for the type and length fields; uses dhmd_pkg.
//
// Splits a byte stream into messages. Each message opens with a header of
// TYPE_DIGITS ASCII digits (type), one ignored separator byte, LENGTH_DIGITS
// ASCII digits (payload length) and one more ignored separator. The byte that
// completes the header yields one header beat with type, length and an error
// flag (non-digit in a digit slot, or a saturated value); each payload byte
// then yields one payload beat. The final beat of a message carries tlast,
// which is the header beat itself for a zero-length message. All other header
// bytes yield no beat. The block takes one byte per cycle unless a held beat
// is stalled by m_tready, and presents its beat in the cycle after the byte is
// taken. The output register frees the input side: a new byte is taken
// whenever the held beat is taken at the same edge or no beat is held.
module decimal_header_message_deframer #(
    parameter int TYPE_DIGITS   = 6,
    parameter int LENGTH_DIGITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [19:0] type_code, [51:20] msg_length,
                                   // [59:52] data_byte, [60] header_error, rest 0
    output logic        m_tuser,   // [0] result_kind
    output logic        m_tlast    // last
);

    localparam int HDR_LEN = TYPE_DIGITS + LENGTH_DIGITS + 2;
    localparam int POS_W   = $clog2(HDR_LEN);
    localparam logic [POS_W-1:0] SEP_POS = POS_W'(TYPE_DIGITS);
    localparam logic [POS_W-1:0] END_POS = POS_W'(HDR_LEN - 1);
    localparam int TW = dhmd_pkg::TYPE_W;
    localparam int LW = dhmd_pkg::LEN_W;

    // Header and payload state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [TW-1:0]    type_acc_reg, type_acc_next;
    logic [LW-1:0]    len_acc_reg, len_acc_next;
    logic [LW-1:0]    remain_reg, remain_next;
    logic             in_payload_reg, in_payload_next;
    logic             err_reg, err_next;

    // Output beat register
    logic                 out_valid_reg, out_valid_next;
    dhmd_pkg::kind_t      out_kind_reg, out_kind_next;
    logic [TW-1:0]        out_type_reg, out_type_next;
    logic [LW-1:0]        out_len_reg, out_len_next;
    logic [7:0]           out_data_reg, out_data_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_err_reg, out_err_next;

    logic          accept;
    logic          produce;
    logic [TW-1:0] type_acc_upd;
    logic [LW-1:0] len_acc_upd;
    logic          type_err;
    logic          len_err;
    logic          is_type_pos;
    logic          is_len_pos;
    logic          is_end_pos;
    logic          fin;

    dhmd_digit_acc #(.W(TW)) u_type_acc (
        .acc     (type_acc_reg),
        .byte_in (s_tdata),
        .acc_out (type_acc_upd),
        .err     (type_err)
    );

    dhmd_digit_acc #(.W(LW)) u_len_acc (
        .acc     (len_acc_reg),
        .byte_in (s_tdata),
        .acc_out (len_acc_upd),
        .err     (len_err)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        is_type_pos = (pos_reg < SEP_POS);
        is_len_pos  = (pos_reg > SEP_POS) && (pos_reg < END_POS);
        is_end_pos  = (pos_reg >= END_POS);
        fin         = (remain_reg <= LW'(1));

        pos_next        = pos_reg;
        type_acc_next   = type_acc_reg;
        len_acc_next    = len_acc_reg;
        remain_next     = remain_reg;
        in_payload_next = in_payload_reg;
        err_next        = err_reg;
        produce         = 1'b0;

        out_kind_next = dhmd_pkg::KIND_PAYLOAD;
        out_type_next = '0;
        out_len_next  = '0;
        out_data_next = '0;
        out_last_next = 1'b0;
        out_err_next  = 1'b0;

        if (accept)
        begin
            if (in_payload_reg)
            begin
                // Pass the payload byte through, count down the remainder
                produce       = 1'b1;
                out_kind_next = dhmd_pkg::KIND_PAYLOAD;
                out_data_next = s_tdata;
                out_last_next = fin;
                if (fin)
                begin
                    remain_next     = '0;
                    in_payload_next = 1'b0;
                end
                else
                begin
                    remain_next = remain_reg - LW'(1);
                end
            end
            else if (is_end_pos)
            begin
                // Closing separator: emit the header and restart
                produce         = 1'b1;
                out_kind_next   = dhmd_pkg::KIND_HEADER;
                out_type_next   = type_acc_reg;
                out_len_next    = len_acc_reg;
                out_last_next   = (len_acc_reg == '0);
                out_err_next    = err_reg;
                remain_next     = len_acc_reg;
                in_payload_next = (len_acc_reg != '0);
                pos_next        = '0;
                type_acc_next   = '0;
                len_acc_next    = '0;
                err_next        = 1'b0;
            end
            else
            begin
                if (is_type_pos)
                begin
                    type_acc_next = type_acc_upd;
                    err_next      = err_reg || type_err;
                end
                else if (is_len_pos)
                begin
                    len_acc_next = len_acc_upd;
                    err_next     = err_reg || len_err;
                end
                pos_next = pos_reg + POS_W'(1);
            end
        end

        if (produce)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            type_acc_reg   <= '0;
            len_acc_reg    <= '0;
            remain_reg     <= '0;
            in_payload_reg <= 1'b0;
            err_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            type_acc_reg   <= type_acc_next;
            len_acc_reg    <= len_acc_next;
            remain_reg     <= remain_next;
            in_payload_reg <= in_payload_next;
            err_reg        <= err_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Load the beat payload only when a new beat is produced
    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            out_kind_reg <= out_kind_next;
            out_type_reg <= out_type_next;
            out_len_reg  <= out_len_next;
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
            out_err_reg  <= out_err_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_err_reg, out_data_reg, out_len_reg, out_type_reg};

    // A zero-length header beat closes its message
    a_zero_len_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == dhmd_pkg::KIND_HEADER) && (out_len_reg == '0))
        |-> m_tlast)
        else $error("zero-length header beat without tlast");

    // Payload beats never carry the header error flag
    a_payload_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == dhmd_pkg::KIND_PAYLOAD)) |-> !out_err_reg)
        else $error("header error set on payload beat");

    // While payload is expected, at least one byte remains
    a_remain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (remain_reg != '0))
        else $error("payload mode with zero bytes remaining");

    // Header position stays within the header
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= END_POS)
        else $error("header position out of range");

    // Header position is idle during payload
    a_pos_idle_payload: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (pos_reg == '0))
        else $error("header position moved during payload");

endmodule
